// ----- sv/dcma_pkg.sv -----
// Shared types and constants for the dual-channel moving-average filter.
package dcma_pkg;

  // Width of the window-length register and its value after reset.
  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIVIDE,
    ST_FINISH
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_write;
    logic capture;
    logic update;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

// ----- sv/dual_channel_moving_average.sv -----
// Top level of the dual-channel boxcar moving-average filter.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | sink      | in_valid_i/in_ready_o | left_value_i, right_value_i
//  out     | source    | out_valid_o/out_ready_i | left_average_o, right_average_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | window_length_i
//
// Each beat runs through these steps: the window read shares the accepting edge,
// then the sum update, the bit-per-cycle restoring dividers and the load into the
// result register, which waits while an earlier result is still stalled. The
// block is idle again in the cycle after the load, so it takes no new input beat
// before the last one is through, and the next one is taken even while the result
// still waits on out_ready_i.
// Reset clears the window (through the fill count), the sums and the slot pointer
// at once and sets the window length to 16; a stalled result holds.
module dual_channel_moving_average #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_value_i,
  input  logic signed [SAMPLE_BITS-1:0] right_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_average_o,
  output logic signed [SAMPLE_BITS-1:0] right_average_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dcma_pkg::CFG_W-1:0]    window_length_i
);

  dcma_pkg::dp_cmd_t    cmd;
  dcma_pkg::dp_status_t sts;

  // Sequence each beat through fetch, update, divide and hand-off.
  dcma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Window memory, running sums and the two dividers, one lane per channel.
  dcma_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .window_length_i(window_length_i),
    .left_value_i   (left_value_i),
    .right_value_i  (right_value_i),
    .left_average_o (left_average_o),
    .right_average_o(right_average_o)
  );

endmodule

// ----- sv/dcma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dcma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dcma_datapath.sv -----
// Datapath: window memory, running sums, two serial dividers and the result register.
module dcma_datapath #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dcma_pkg::dp_cmd_t              cmd_i,
  output dcma_pkg::dp_status_t           sts_o,
  input  logic [dcma_pkg::CFG_W-1:0]     window_length_i,
  input  logic signed [SAMPLE_BITS-1:0]  left_value_i,
  input  logic signed [SAMPLE_BITS-1:0]  right_value_i,
  output logic signed [SAMPLE_BITS-1:0]  left_average_o,
  output logic signed [SAMPLE_BITS-1:0]  right_average_o
);

  localparam int unsigned SLOT_W = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + SLOT_W + 1;
  localparam int unsigned CNT_W  = $clog2(SUM_W);
  localparam int unsigned S      = SAMPLE_BITS;

  logic [dcma_pkg::CFG_W-1:0] win_len_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [SLOT_W:0]            fill_q;
  logic [SLOT_W-1:0]          slot_sel_q;
  logic [CNT_W-1:0]           cnt_q;

  logic signed [S-1:0]     smp_q   [2];
  logic signed [SUM_W-1:0] sum_q   [2];
  logic        [SUM_W-1:0] dvd_q   [2];
  logic        [LEN_W:0]   rem_q   [2];
  logic                    neg_q   [2];
  logic signed [S-1:0]     avg_q   [2];

  logic [31:0]             len_wide;
  logic [LEN_W-1:0]        eff_len;
  logic [SLOT_W-1:0]       slot_pick;
  logic [31:0]             slot_inc;
  logic [SLOT_W-1:0]       slot_next;
  logic                    old_valid;
  logic [2*S-1:0]          rdata;
  logic signed [S-1:0]     old_smp [2];
  logic signed [SUM_W-1:0] new_sum [2];
  logic        [SUM_W-1:0] mag     [2];
  logic        [LEN_W:0]   rem_sh  [2];
  logic        [LEN_W:0]   rem_nx  [2];
  logic                    qbit    [2];
  logic        [SUM_W-1:0] signed_q [2];

  // Effective length: zero acts as one, above the window depth saturates.
  always_comb begin
    if (win_len_q == '0) begin
      len_wide = 32'd1;
    end else if (32'(win_len_q) > MAX_WINDOW) begin
      len_wide = 32'(MAX_WINDOW);
    end else begin
      len_wide = 32'(win_len_q);
    end
    eff_len = len_wide[LEN_W-1:0];
  end

  // Slot to overwrite, and where the pointer goes afterwards.
  always_comb begin
    slot_pick = (32'(slot_q) >= 32'(eff_len)) ? '0 : slot_q;
    slot_inc  = 32'(slot_sel_q) + 32'd1;
    slot_next = (slot_inc >= 32'(eff_len)) ? '0 : slot_inc[SLOT_W-1:0];
    // Slots are filled in order from zero, so a slot below the fill count holds data.
    old_valid = 32'(slot_sel_q) < 32'(fill_q);
  end

  dcma_ram #(
    .WIDTH(2 * S),
    .DEPTH(MAX_WINDOW)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.update),
    .waddr_i(slot_sel_q),
    .wdata_i({smp_q[1], smp_q[0]}),
    .raddr_i(slot_pick),
    .rdata_o(rdata)
  );

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      old_smp[i]  = old_valid ? $signed(rdata[i*S +: S]) : '0;
      new_sum[i]  = sum_q[i] + SUM_W'(smp_q[i]) - SUM_W'(old_smp[i]);
      mag[i]      = new_sum[i][SUM_W-1] ? SUM_W'(-new_sum[i]) : SUM_W'(new_sum[i]);
      // Restoring division step: shift in one dividend bit, subtract when it fits.
      rem_sh[i]   = {rem_q[i][LEN_W-1:0], dvd_q[i][SUM_W-1]};
      qbit[i]     = rem_sh[i] >= {1'b0, eff_len};
      rem_nx[i]   = qbit[i] ? (rem_sh[i] - {1'b0, eff_len}) : rem_sh[i];
      signed_q[i] = neg_q[i] ? (~dvd_q[i] + 1'b1) : dvd_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= dcma_pkg::WINDOW_RESET;
      slot_q    <= '0;
      fill_q    <= '0;
      cnt_q     <= '0;
      for (int i = 0; i < 2; i++) begin
        sum_q[i] <= '0;
      end
    end else if (cmd_i.cfg_write) begin
      // New length: drop the window contents and restart from slot zero.
      win_len_q <= window_length_i;
      slot_q    <= '0;
      fill_q    <= '0;
      for (int i = 0; i < 2; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      if (cmd_i.update) begin
        slot_q <= slot_next;
        if (32'(slot_sel_q) == 32'(fill_q)) begin
          fill_q <= fill_q + 1'b1;
        end
        for (int i = 0; i < 2; i++) begin
          sum_q[i] <= new_sum[i];
        end
        cnt_q <= CNT_W'(SUM_W - 1);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q[0]   <= left_value_i;
      smp_q[1]   <= right_value_i;
      slot_sel_q <= slot_pick;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd_i.update) begin
        neg_q[i] <= new_sum[i][SUM_W-1];
        dvd_q[i] <= mag[i];
        rem_q[i] <= '0;
      end else if (cmd_i.div_step) begin
        dvd_q[i] <= {dvd_q[i][SUM_W-2:0], qbit[i]};
        rem_q[i] <= rem_nx[i];
      end
      if (cmd_i.load_out) begin
        avg_q[i] <= $signed(signed_q[i][S-1:0]);
      end
    end
  end

  assign sts_o.div_done  = (cnt_q == '0);
  assign left_average_o  = avg_q[0];
  assign right_average_o = avg_q[1];

endmodule

// ----- sv/dcma_ctrl.sv -----
// Controller: sequences fetch, update, divide and result hand-off for one beat.
module dcma_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  output dcma_pkg::dp_cmd_t    cmd_o,
  input  dcma_pkg::dp_status_t sts_i
);

  dcma_pkg::ctl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcma_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      dcma_pkg::ST_IDLE: begin
        // Hold off input beats while a configuration beat is offered.
        cfg_ready_o     = 1'b1;
        in_ready_o      = !cfg_valid_i;
        cmd_o.cfg_write = cfg_valid_i;
        cmd_o.capture   = in_valid_i && !cfg_valid_i;
        if (cmd_o.capture) begin
          state_d = dcma_pkg::ST_FETCH;
        end
      end
      dcma_pkg::ST_FETCH: begin
        cmd_o.update = 1'b1;
        state_d      = dcma_pkg::ST_DIVIDE;
      end
      dcma_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = dcma_pkg::ST_FINISH;
        end
      end
      dcma_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = dcma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/dcma_checker.sv -----
// Port-level checks for the moving-average filter, bound to the top level.
module dcma_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic signed [SAMPLE_BITS-1:0] left_value_i,
  input logic signed [SAMPLE_BITS-1:0] right_value_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] left_average_o,
  input logic signed [SAMPLE_BITS-1:0] right_average_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [dcma_pkg::CFG_W-1:0]    window_length_i
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_average_o)
      && $stable(right_average_o))
    else $error("result changed while stalled");

  // One beat at a time: no new input straight after an accepted one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // Configuration and input beats never complete together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o && in_valid_i && in_ready_o))
    else $error("configuration and input accepted together");

  // A fresh result appears only at the end of a busy spell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o) && $past(!cfg_ready_o))
    else $error("result raised without work in progress");

endmodule

bind dual_channel_moving_average dcma_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_dcma_checker (.*);
